// ===== rtl/hptm_pkg.sv =====
// Shared types, constants and the display code table of the tone mapper.
package hptm_pkg;

  localparam int X_W       = 40;
  localparam logic [X_W-1:0] XCAP = {X_W{1'b1}};
  localparam int MANT_W    = 31;
  localparam int FRAC_W    = 24;
  localparam int LOG_W     = 32;
  localparam int LN_W      = 30;
  localparam int V_W       = 50;
  localparam int TAB_W     = 27;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_EXPOSURE_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFOG_RED     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFOG_GREEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEFOG_BLUE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KNEE_START    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KNEE_FACTOR   = 3'd5;

  localparam logic [31:0] RST_EXPOSURE_GAIN = 32'd364100;
  localparam logic [31:0] RST_KNEE_START    = 32'd65536;
  localparam logic [31:0] RST_KNEE_FACTOR   = 32'd3103785;

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [31:0] GAMMA_Q32 = 32'd1952055624;
  localparam logic signed [31:0] SCALE_LOG2_Q24 = 32'sd107434724;
  localparam logic signed [31:0] LOG_BIAS = 32'sd536870912;
  localparam logic signed [31:0] Z_OFFSET =
    SCALE_LOG2_Q24 - $signed({3'b000, GAMMA_Q32[31:3]});
  localparam logic signed [31:0] SAT_LIM = 32'sd134217728;

  typedef struct packed {
    logic [31:0] gain;
    logic [31:0] knee_start;
    logic [31:0] knee_factor;
  } tone_cfg_t;

  typedef logic [255:0][TAB_W-1:0] log_tab_t;

  // log2 of every display code in Q.24, by the same squaring method as the datapath.
  function automatic log_tab_t build_log_tab();
    log_tab_t tab;
    logic [63:0] m;
    logic [FRAC_W-1:0] fr;
    int p;
    tab = '0;
    for (int n = 1; n < 256; n++) begin
      p = 0;
      for (int b = 0; b < 8; b++) begin
        if (n[b]) p = b;
      end
      m = 64'(n) << (30 - p);
      fr = '0;
      for (int i = 0; i < FRAC_W; i++) begin
        m = (m * m) >> 30;
        fr = {fr[FRAC_W-2:0], 1'b0};
        if (m >= 64'h8000_0000) begin
          fr[0] = 1'b1;
          m = m >> 1;
        end
      end
      tab[n] = {3'(p), fr};
    end
    return tab;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

// ===== rtl/hptm_sq_cell.sv =====
// One squaring step of the logarithm chain, yielding one fraction bit.
module hptm_sq_cell
  import hptm_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vin,
  input  logic [MANT_W-1:0] m_in,
  input  logic [FRAC_W-1:0] f_in,
  input  logic [SIDE_W-1:0] s_in,
  output logic              vout,
  output logic [MANT_W-1:0] m_out,
  output logic [FRAC_W-1:0] f_out,
  output logic [SIDE_W-1:0] s_out
);

  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     sh;

  assign sq = (2*MANT_W)'(m_in) * (2*MANT_W)'(m_in);
  assign sh = sq[2*MANT_W-1:MANT_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_out <= {f_in[FRAC_W-2:0], sh[MANT_W]};
      m_out <= sh[MANT_W] ? sh[MANT_W:1] : sh[MANT_W-1:0];
      s_out <= s_in;
    end
  end

endmodule

// ===== rtl/hptm_log2.sv =====
// Pipelined base-two logarithm: two normalising stages and a row of squaring cells.
module hptm_log2
  import hptm_pkg::*;
#(
  parameter int IN_W      = 40,
  parameter int FRAC_BITS = 16,
  parameter int SIDE_W    = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    vin,
  input  logic [IN_W-1:0]         v,
  input  logic [SIDE_W-1:0]       side_in,
  output logic                    vout,
  output logic signed [LOG_W-1:0] l,
  output logic [SIDE_W-1:0]       side_out
);

  localparam int NB   = (IN_W + 7) / 8;
  localparam int CB   = (NB > 1) ? $clog2(NB) : 1;
  localparam int P_W  = $clog2(IN_W);
  localparam int CS_W = SIDE_W + P_W;

  logic [NB*8-1:0]   vp;
  logic [CB-1:0]     ca_n;
  logic [IN_W-1:0]   va;
  logic [CB-1:0]     ca;
  logic              vla;
  logic [SIDE_W-1:0] sidea;

  logic [7:0]        byte_v;
  logic [2:0]        fine;
  logic [P_W-1:0]    pb_n;
  logic [MANT_W-1:0] mb_n;

  logic              cv [FRAC_W+1];
  logic [MANT_W-1:0] cm [FRAC_W+1];
  logic [FRAC_W-1:0] cf [FRAC_W+1];
  logic [CS_W-1:0]   cs [FRAC_W+1];

  logic [LOG_W-1:0]  ip;
  logic [P_W-1:0]    p_out;

  // Coarse search: the highest non-zero byte.
  always_comb begin
    vp = (NB*8)'(v);
    ca_n = '0;
    for (int b = 0; b < NB; b++) begin
      if (|vp[8*b +: 8]) ca_n = CB'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vla <= 1'b0;
    end else if (en) begin
      vla <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      va    <= v;
      ca    <= ca_n;
      sidea <= side_in;
    end
  end

  // Fine search inside that byte, then normalise the mantissa to Q1.30.
  always_comb begin
    byte_v = 8'(va >> (8 * ca));
    fine = '0;
    for (int b = 0; b < 8; b++) begin
      if (byte_v[b]) fine = 3'(b);
    end
    pb_n = P_W'({ca, 3'b000}) + P_W'(fine);
    if (pb_n >= 30) begin
      mb_n = MANT_W'(va >> (pb_n - 30));
    end else begin
      mb_n = MANT_W'(va) << (30 - pb_n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= vla;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cm[0] <= mb_n;
      cs[0] <= {pb_n, sidea};
    end
  end

  assign cf[0] = '0;

  for (genvar i = 0; i < FRAC_W; i++) begin : g_cell
    hptm_sq_cell #(.SIDE_W(CS_W)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .vin   (cv[i]),
      .m_in  (cm[i]),
      .f_in  (cf[i]),
      .s_in  (cs[i]),
      .vout  (cv[i+1]),
      .m_out (cm[i+1]),
      .f_out (cf[i+1]),
      .s_out (cs[i+1])
    );
  end

  assign p_out    = cs[FRAC_W][CS_W-1:SIDE_W];
  assign side_out = cs[FRAC_W][SIDE_W-1:0];
  assign vout     = cv[FRAC_W];
  assign ip       = LOG_W'(p_out) - LOG_W'(FRAC_BITS);
  assign l        = $signed({ip[LOG_W-FRAC_W-1:0], cf[FRAC_W]});

endmodule

// ===== rtl/hptm_div_cell.sv =====
// One restoring division step: one quotient bit per cell.
module hptm_div_cell #(
  parameter int NUM_W  = 46,
  parameter int DEN_W  = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vin,
  input  logic [DEN_W-1:0]  den,
  input  logic [NUM_W-1:0]  n_in,
  input  logic [DEN_W-1:0]  r_in,
  input  logic [NUM_W-1:0]  q_in,
  input  logic [SIDE_W-1:0] s_in,
  output logic              vout,
  output logic [NUM_W-1:0]  n_out,
  output logic [DEN_W-1:0]  r_out,
  output logic [NUM_W-1:0]  q_out,
  output logic [SIDE_W-1:0] s_out
);

  logic [DEN_W:0] r2;
  logic [DEN_W:0] diff;
  logic           ge;

  assign r2   = {r_in, n_in[NUM_W-1]};
  assign diff = r2 - {1'b0, den};
  assign ge   = r2 >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_out <= n_in << 1;
      r_out <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
      q_out <= {q_in[NUM_W-2:0], ge};
      s_out <= s_in;
    end
  end

endmodule

// ===== rtl/hptm_channel.sv =====
// Full tone curve for one colour channel, one pixel a cycle while en is high.
module hptm_channel
  import hptm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        vin,
  input  logic [15:0] h,
  input  logic [31:0] defog,
  input  tone_cfg_t   cfg,
  output logic        vout,
  output logic [7:0]  y
);

  localparam int SH    = FRAC_BITS - 16;
  localparam int NUM_W = LN_W + FRAC_BITS;
  localparam int SUM_W = ((NUM_W > X_W) ? NUM_W : X_W) + 1;
  localparam logic signed [6:0] FB_S = 7'(FRAC_BITS);

  function automatic logic [X_W-1:0] from_q16(input logic [31:0] q);
    if (SH >= 0) return X_W'(q) << SH;
    else return X_W'(q >> (-SH));
  endfunction

  logic [X_W-1:0] kl;
  logic [X_W-1:0] dfg;
  assign kl  = from_q16(cfg.knee_start);
  assign dfg = from_q16(defog);

  // Half-float decode; infinity, NaN and negative inputs become zero.
  logic [4:0]        e;
  logic [10:0]       mant;
  logic signed [6:0] s;
  logic [X_W-1:0]    xd;

  always_comb begin
    e = h[14:10];
    mant = {(e != 5'd0), h[9:0]};
    s = $signed({2'b00, ((e == 5'd0) ? 5'd1 : e)}) - 7'sd25 + FB_S;
    if (e == 5'd31 || h[15]) begin
      xd = '0;
    end else if (s >= 0) begin
      xd = X_W'(mant) << s;
    end else begin
      xd = X_W'(mant >> (-s));
    end
  end

  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10;
  logic [X_W-1:0]    x1, x3, x4, x5, x6, x7, xk8;
  logic [X_W+15:0]   ph2, pl2, a5, b5;
  logic [X_W-1:0]    u4;
  logic              knee4, knee5, knee6, knee7;
  logic [V_W-1:0]    vk6;
  logic [LN_W-1:0]   ln7;
  logic              zero8, zero9;
  logic [61:0]       gp9;

  logic [X_W+16:0]   sum3;
  logic [56:0]       tl;
  logic [48:0]       t;
  logic [61:0]       lp;
  logic [SUM_W-1:0]  ks;
  logic [X_W-1:0]    xk;
  logic signed [31:0] w;
  logic signed [31:0] z;

  logic                    lv1;
  logic signed [LOG_W-1:0] l1;
  logic [X_W:0]            ls1;
  logic                    lv2;
  logic signed [LOG_W-1:0] l2;
  logic                    ls2;

  logic             dv [NUM_W+1];
  logic [NUM_W-1:0] dn [NUM_W+1];
  logic [31:0]      dr [NUM_W+1];
  logic [NUM_W-1:0] dq [NUM_W+1];
  logic [X_W:0]     ds [NUM_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0;
    end else if (en) begin
      v1 <= vin; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      v6 <= v5; v7 <= lv1; v8 <= dv[NUM_W]; v9 <= lv2; v10 <= v9;
    end
  end

  always_comb begin
    sum3 = {1'b0, ph2} + (X_W+17)'(pl2 >> 16);
    tl = 57'({a5[7:0], 16'h0000}) + 57'(b5);
    t = 49'(a5 >> 8) + 49'(tl >> 24);
    lp = 62'(l1[LN_W-1:0]) * 62'(LN2_Q32);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1    <= (xd > dfg) ? xd - dfg : '0;
      ph2   <= x1 * cfg.gain[31:16];
      pl2   <= x1 * cfg.gain[15:0];
      x3    <= (sum3 > (X_W+17)'(XCAP)) ? XCAP : sum3[X_W-1:0];
      knee4 <= (x3 > kl) && (cfg.knee_factor != 32'd0);
      u4    <= x3 - kl;
      x4    <= x3;
      a5    <= u4 * cfg.knee_factor[31:16];
      b5    <= u4 * cfg.knee_factor[15:0];
      knee5 <= knee4;
      x5    <= x4;
      vk6   <= V_W'(t) + (V_W'(1) << FRAC_BITS);
      x6    <= x5;
      knee6 <= knee5;
      ln7   <= lp[61:32];
      x7    <= ls1[X_W:1];
      knee7 <= ls1[0];
    end
  end

  hptm_log2 #(.IN_W(V_W), .FRAC_BITS(FRAC_BITS), .SIDE_W(X_W + 1)) u_log_knee (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (v6),
    .v        (vk6),
    .side_in  ({x6, knee6}),
    .vout     (lv1),
    .l        (l1),
    .side_out (ls1)
  );

  // Quotient of the knee logarithm by the knee factor, one bit a cell.
  assign dv[0] = v7;
  assign dn[0] = {ln7, {FRAC_BITS{1'b0}}};
  assign dr[0] = '0;
  assign dq[0] = '0;
  assign ds[0] = {x7, knee7};

  for (genvar i = 0; i < NUM_W; i++) begin : g_div
    hptm_div_cell #(.NUM_W(NUM_W), .DEN_W(32), .SIDE_W(X_W + 1)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .vin   (dv[i]),
      .den   (cfg.knee_factor),
      .n_in  (dn[i]),
      .r_in  (dr[i]),
      .q_in  (dq[i]),
      .s_in  (ds[i]),
      .vout  (dv[i+1]),
      .n_out (dn[i+1]),
      .r_out (dr[i+1]),
      .q_out (dq[i+1]),
      .s_out (ds[i+1])
    );
  end

  always_comb begin
    ks = SUM_W'(kl) + SUM_W'(dq[NUM_W]);
    if (ds[NUM_W][0]) begin
      xk = (ks > SUM_W'(XCAP)) ? XCAP : ks[X_W-1:0];
    end else begin
      xk = ds[NUM_W][X_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xk8   <= xk;
      zero8 <= (xk == '0);
    end
  end

  hptm_log2 #(.IN_W(X_W), .FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_log_gamma (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (v8),
    .v        (xk8),
    .side_in  (zero8),
    .vout     (lv2),
    .l        (l2),
    .side_out (ls2)
  );

  // Gamma and display scale in the log domain.
  assign w = l2 + LOG_BIAS;
  assign z = $signed({2'b00, gp9[61:32]}) + Z_OFFSET;

  logic             sv   [9];
  logic [7:0]       sn   [9];
  logic [TAB_W-1:0] sz   [9];
  logic             sneg [9];
  logic             ssat [9];

  always_ff @(posedge clk) begin
    if (en) begin
      gp9     <= 62'(w[30:0]) * 62'(GAMMA_Q32[30:0]);
      zero9   <= ls2;
      sz[0]   <= z[TAB_W-1:0];
      sneg[0] <= zero9 || (z < 0);
      ssat[0] <= (z >= SAT_LIM);
    end
  end

  assign sv[0] = v10;
  assign sn[0] = '0;

  // Binary search for the largest code whose logarithm does not exceed z.
  for (genvar j = 0; j < 8; j++) begin : g_srch
    logic [7:0] cand;
    assign cand = sn[j] | (8'd1 << (7 - j));

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j+1] <= 1'b0;
      end else if (en) begin
        sv[j+1] <= sv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sn[j+1]   <= (LOG_TAB[cand] <= sz[j]) ? cand : sn[j];
        sz[j+1]   <= sz[j];
        sneg[j+1] <= sneg[j];
        ssat[j+1] <= ssat[j];
      end
    end
  end

  assign vout = sv[8];
  assign y    = sneg[8] ? 8'h00 : (ssat[8] ? 8'hFF : sn[8]);

endmodule

// ===== rtl/half_pixel_tone_map.sv =====
// Throughput: one pixel per cycle while the skid entry is empty; the knee divider
// (one quotient bit per cell) and the two 26-stage logarithm chains set the depth,
// not the rate.
// The output register with a skid entry lets the pipeline run while a result waits.
// Reset (synchronous) empties the pipeline and loads the register defaults.
// Top level: configuration registers, three channel pipelines and the output buffer.
module half_pixel_tone_map
  import hptm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [15:0]          red_in,
  input  logic [15:0]          green_in,
  input  logic [15:0]          blue_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           red_out,
  output logic [7:0]           green_out,
  output logic [7:0]           blue_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic [31:0] exposure_gain, defog_red, defog_green, defog_blue;
  logic [31:0] knee_start, knee_factor;
  tone_cfg_t   cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      exposure_gain <= RST_EXPOSURE_GAIN;
      defog_red     <= '0;
      defog_green   <= '0;
      defog_blue    <= '0;
      knee_start    <= RST_KNEE_START;
      knee_factor   <= RST_KNEE_FACTOR;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EXPOSURE_GAIN: exposure_gain <= cfg_data;
        REG_DEFOG_RED:     defog_red     <= cfg_data;
        REG_DEFOG_GREEN:   defog_green   <= cfg_data;
        REG_DEFOG_BLUE:    defog_blue    <= cfg_data;
        REG_KNEE_START:    knee_start    <= cfg_data;
        REG_KNEE_FACTOR:   knee_factor   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg = '{gain: exposure_gain, knee_start: knee_start, knee_factor: knee_factor};

  logic       skid_valid;
  logic       en;
  logic       rv, gv, bv, pv, push, free;
  logic [7:0] ry, gy, by;
  logic [7:0] skid_r, skid_g, skid_b;

  // The pipeline only halts once the skid entry is occupied.
  assign en       = !skid_valid;
  assign in_ready = en;

  hptm_channel #(.FRAC_BITS(FRAC_BITS)) u_red (
    .clk(clk), .rst(rst), .en(en), .vin(in_valid), .h(red_in),
    .defog(defog_red), .cfg(cfg), .vout(rv), .y(ry)
  );

  hptm_channel #(.FRAC_BITS(FRAC_BITS)) u_green (
    .clk(clk), .rst(rst), .en(en), .vin(in_valid), .h(green_in),
    .defog(defog_green), .cfg(cfg), .vout(gv), .y(gy)
  );

  hptm_channel #(.FRAC_BITS(FRAC_BITS)) u_blue (
    .clk(clk), .rst(rst), .en(en), .vin(in_valid), .h(blue_in),
    .defog(defog_blue), .cfg(cfg), .vout(bv), .y(by)
  );

  assign pv   = rv & gv & bv;
  assign push = pv && en;
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (free) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (free) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (free) begin
        red_out   <= skid_r;
        green_out <= skid_g;
        blue_out  <= skid_b;
      end
    end else if (push) begin
      if (free) begin
        red_out   <= ry;
        green_out <= gy;
        blue_out  <= by;
      end else begin
        skid_r <= ry;
        skid_g <= gy;
        skid_b <= by;
      end
    end
  end

  // The three channel pipelines must stay in lock step.
  a_lock_step: assert property (@(posedge clk) disable iff (rst)
    (rv == gv) && (gv == bv))
    else $error("channel pipelines out of step");

  // The skid entry holds a result only behind a full output register.
  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry occupied with empty output register");

  // The skid entry fills only when the consumer stalled a waiting result.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid entry filled without a stall");

endmodule

// ===== tb/sv/half_pixel_tone_map_tb.sv =====
// Self-checking testbench for the half-float pixel tone mapper.
module half_pixel_tone_map_tb;
  import hptm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam int WATCH_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
  localparam logic [63:0] XMAX = (64'd1 << 40) - 64'd1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] red_in = '0, green_in = '0, blue_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] red_out, green_out, blue_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  half_pixel_tone_map #(.FRAC_BITS(FB)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb8_t;

  rgb8_t pixels_due[$];
  logic [31:0] m_gain, m_dr, m_dg, m_db, m_kstart, m_kfac;
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;

  function automatic longint log2_fx(logic [63:0] v, int fb);
    int p;
    logic [63:0] m;
    longint fr;
    p = 0;
    for (int i = 0; i < 64; i++) if (v[i]) p = i;
    m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
    fr = 0;
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      fr = fr << 1;
      if (m >= 64'h8000_0000) begin
        fr = fr | 1;
        m = m >> 1;
      end
    end
    return longint'(p - fb) * 64'sd16777216 + fr;
  endfunction

  function automatic logic [7:0] map_channel(logic [15:0] h, logic [31:0] defog);
    logic [63:0] x, kl, k, u, a, b, t, l, ln;
    int e, s;
    longint lx, z;
    e = h[14:10];
    if (e == 31 || h[15]) return 8'd0;
    x = {54'd0, h[9:0]};
    if (e != 0) x[10] = 1'b1;
    else e = 1;
    s = e - 25 + FB;
    x = (s >= 0) ? (x << s) : (x >> (-s));
    x = (x > defog) ? x - defog : 64'd0;
    x = x * m_gain[31:16] + ((x * m_gain[15:0]) >> 16);
    if (x > XMAX) x = XMAX;
    kl = m_kstart;
    k = m_kfac;
    if (x > kl && k != 0) begin
      u = x - kl;
      a = u * k[31:16];
      b = u * k[15:0];
      t = (a >> 8) + ((((a & 64'd255) << 16) + b) >> 24);
      l = log2_fx(t + (64'd1 << FB), FB);
      ln = (l * 64'(LN2_Q32)) >> 32;
      x = kl + (ln << FB) / k;
      if (x > XMAX) x = XMAX;
    end
    if (x == 0) return 8'd0;
    lx = log2_fx(x, FB);
    z = longint'((64'(lx + 32 * 64'sd16777216) * 64'(GAMMA_Q32)) >> 32)
        + 64'sd107434724 - longint'(GAMMA_Q32 >> 3);
    if (z < 0) return 8'd0;
    if (z >= 8 * 64'sd16777216) return 8'd255;
    for (int n = 255; n >= 1; n--) if (log2_fx(64'(n), 0) <= z) return 8'(n);
    return 8'd0;
  endfunction

  // Valid stays high between back-to-back transfers and drops only while idling.
  task automatic push_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    while (send_idle > 0 && $urandom_range(99, 0) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_due.push_back('{map_channel(r, m_dr), map_channel(g, m_dg),
                           map_channel(b, m_db)});
    @(negedge clk);
  endtask

  // Waits for the pipeline to empty so that registers change only while idle.
  task automatic drain;
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_EXPOSURE_GAIN: m_gain = val;
      REG_DEFOG_RED: m_dr = val;
      REG_DEFOG_GREEN: m_dg = val;
      REG_DEFOG_BLUE: m_db = val;
      REG_KNEE_START: m_kstart = val;
      REG_KNEE_FACTOR: m_kfac = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_setup(logic [31:0] g, logic [31:0] dr, logic [31:0] dg,
                            logic [31:0] db, logic [31:0] ks, logic [31:0] kf);
    drain();
    write_reg(REG_EXPOSURE_GAIN, g);
    write_reg(REG_DEFOG_RED, dr);
    write_reg(REG_DEFOG_GREEN, dg);
    write_reg(REG_DEFOG_BLUE, db);
    write_reg(REG_KNEE_START, ks);
    write_reg(REG_KNEE_FACTOR, kf);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_half();
    int c;
    c = $urandom_range(9, 0);
    if (c == 0) return 16'($urandom);
    if (c == 1) return {1'b0, 5'd0, 10'($urandom)};
    if (c == 2) return {1'b0, 5'd31, 10'($urandom)};
    return {1'b0, 5'($urandom_range(30, 5)), 10'($urandom)};
  endfunction

  task automatic test_directed;
    logic [15:0] corner [0:11];
    corner = '{16'h0000, 16'h8000, 16'h0001, 16'h03FF, 16'h0400, 16'h3C00,
               16'h4000, 16'h7BFF, 16'h7C00, 16'h7E00, 16'hFC00, 16'hBC00};
    for (int i = 0; i < 12; i++) push_pixel(corner[i], corner[(i + 4) % 12],
                                            corner[(i + 8) % 12]);
    push_pixel(16'h3800, 16'h3A00, 16'h2E66);
    push_pixel(16'hFFFF, 16'h5555, 16'hAAAA);
  endtask

  task automatic test_registers;
    load_setup(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
    test_directed();
    load_setup(32'd0, 32'hFFFF_FFFF, 32'h0000_8000, 32'd1, 32'hFFFF_FFFF,
               32'hFFFF_FFFF);
    test_directed();
    load_setup(32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0);
    test_directed();
    // An index past the last register must leave every register unchanged.
    drain();
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    cfg_valid <= 1'b0;
    push_pixel(16'h3C00, 16'h4400, 16'h5000);
  endtask

  task automatic test_random_phase(int n, int sidle, int rstall);
    send_idle = sidle;
    recv_stall = rstall;
    for (int i = 0; i < n; i++) push_pixel(rand_half(), rand_half(), rand_half());
  endtask

  task automatic test_random_setups;
    for (int s = 0; s < 4; s++) begin
      send_idle = 0;
      recv_stall = 0;
      load_setup($urandom_range(1 << 22, 0), $urandom_range(1 << 17, 0),
                 $urandom_range(1 << 17, 0), $urandom_range(1 << 17, 0),
                 $urandom_range(1 << 19, 0), $urandom_range(1 << 26, 1));
      test_random_phase(100, 0, 0);
      test_random_phase(60, 83, 0);
      test_random_phase(60, 0, 83);
      test_random_phase(40, 29, 29);
    end
  endtask

  // Results are sampled at the rising edge; ready changes on the falling edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        $error("unexpected pixel r=%0d g=%0d b=%0d", red_out, green_out, blue_out);
        errors++;
      end else begin
        rgb8_t exp_px;
        exp_px = pixels_due.pop_front();
        if (red_out !== exp_px.r) begin
          $error("red_out expected %0d actual %0d", exp_px.r, red_out); errors++;
        end
        if (green_out !== exp_px.g) begin
          $error("green_out expected %0d actual %0d", exp_px.g, green_out); errors++;
        end
        if (blue_out !== exp_px.b) begin
          $error("blue_out expected %0d actual %0d", exp_px.b, blue_out); errors++;
        end
      end
    end
  end

  always @(negedge clk) out_ready <= !(recv_stall > 0 && $urandom_range(99, 0) < recv_stall);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("[half_pixel_tone_map] ERROR");
      $finish;
    end
  end

  initial begin
    m_gain = RST_EXPOSURE_GAIN;
    m_dr = '0;
    m_dg = '0;
    m_db = '0;
    m_kstart = RST_KNEE_START;
    m_kfac = RST_KNEE_FACTOR;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_registers();
    test_random_setups();
    drain();
    if (errors == 0) $display("[half_pixel_tone_map] OK");
    else $display("[half_pixel_tone_map] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/hptm_pkg.sv
rtl/hptm_sq_cell.sv
rtl/hptm_log2.sv
rtl/hptm_div_cell.sv
rtl/hptm_channel.sv
rtl/half_pixel_tone_map.sv
tb/sv/half_pixel_tone_map_tb.sv
